### rtl/ptet_pkg.sv
// ---------------------------------------------------------------------------
// ptet_pkg: shared types and constants of the pointer/touch event tracker
// Command, event, lock and register index codes, the scale unit interface
// structs and the coordinate saturation helper.
// ---------------------------------------------------------------------------
`default_nettype none

package ptet_pkg;

   // Coordinate range of scaled touch positions
   localparam int unsigned CoordBits  = 16;
   localparam logic [63:0] CoordLimit = (64'd1 << CoordBits) - 64'd1;

   // Double-click radius in screen units, multiplied by ui_scale
   localparam logic [4:0] ClickRadius = 5'd25;

   // Input commands
   localparam logic [1:0] CmdMouse   = 2'd0;
   localparam logic [1:0] CmdTouch   = 2'd1;
   localparam logic [1:0] CmdSetPos  = 2'd2;
   localparam logic [1:0] CmdReadPos = 2'd3;

   // Result event kinds
   localparam logic [1:0] EvPos     = 2'd0;
   localparam logic [1:0] EvPress   = 2'd1;
   localparam logic [1:0] EvRelease = 2'd2;
   localparam logic [1:0] EvDouble  = 2'd3;

   // Lock owner codes; the fourth code counts as unlocked
   localparam logic [1:0] LockNone  = 2'd0;
   localparam logic [1:0] LockMouse = 2'd1;
   localparam logic [1:0] LockTouch = 2'd2;

   // Configuration register indexes
   localparam int unsigned CsrIdxBits = 3;
   localparam logic [2:0] CsrScreenWidth  = 3'd0;
   localparam logic [2:0] CsrScreenHeight = 3'd1;
   localparam logic [2:0] CsrUiScale      = 3'd2;
   localparam logic [2:0] CsrTouchMinX    = 3'd3;
   localparam logic [2:0] CsrTouchMaxX    = 3'd4;
   localparam logic [2:0] CsrTouchMinY    = 3'd5;
   localparam logic [2:0] CsrTouchMaxY    = 3'd6;

   // Scale unit request: one raw axis sample and its calibration
   typedef struct packed {
      logic        start;
      logic [31:0] raw;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [15:0] size;
   } scl_req_type;

   // Scale unit response: one-cycle done pulse with the screen coordinate
   typedef struct packed {
      logic        done;
      logic [15:0] value;
   } scl_rsp_type;

   // Clip a quotient to the coordinate range
   function automatic logic [15:0] sat_coord(input logic [15:0] q);
      logic [15:0] r;
      r = q;
      if ({48'd0, q} > CoordLimit) begin
         r = CoordLimit[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/ptet_scale.sv
// ---------------------------------------------------------------------------
// ptet_scale: raw touch axis to screen coordinate
// Clamps the raw value to [lo,hi], multiplies (raw-lo) by the screen size
// and divides by (hi-lo) with a restoring divider, one quotient bit a cycle.
// The quotient never exceeds the size, so 16 steps cover it.
// ---------------------------------------------------------------------------
`default_nettype none

module ptet_scale (
   input  wire                   clock,
   input  wire                   reset,
   input  ptet_pkg::scl_req_type scl_req,
   output ptet_pkg::scl_rsp_type scl_rsp
);
   import ptet_pkg::*;

   localparam logic [1:0] ScIdle = 2'd0;
   localparam logic [1:0] ScMul  = 2'd1;
   localparam logic [1:0] ScDiv  = 2'd2;

   logic [1:0]  st_ff, st_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [31:0] diff_ff;
   logic [15:0] size_ff;
   logic [31:0] dvs_ff;
   logic        empty_ff;
   logic [31:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;

   logic [31:0] clamped;
   logic [47:0] prod;
   logic [32:0] trial;
   logic [32:0] trial_sub;
   logic        trial_ge;

   // Clamp the raw sample into the calibrated range
   always_comb begin
      clamped = scl_req.raw;
      if (scl_req.raw < scl_req.lo) begin
         clamped = scl_req.lo;
      end else if (scl_req.raw > scl_req.hi) begin
         clamped = scl_req.hi;
      end
   end

   // Product and one restoring division step
   assign prod      = 48'(diff_ff) * 48'(size_ff);
   assign trial     = {rem_ff, quo_ff[15]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign trial_ge  = trial >= {1'b0, dvs_ff};

   // Sequencer
   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      unique case (st_ff)
         ScIdle: begin
            if (scl_req.start) begin
               st_in = ScMul;
            end
         end
         ScMul: begin
            rem_in = prod[47:16];
            quo_in = prod[15:0];
            cnt_in = 4'd0;
            st_in  = ScDiv;
         end
         ScDiv: begin
            rem_in = trial_ge ? trial_sub[31:0] : trial[31:0];
            quo_in = {quo_ff[14:0], trial_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               done_in = 1'b1;
               st_in   = ScIdle;
            end
         end
         default: begin
            st_in = ScIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ScIdle;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and datapath registers
   always_ff @(posedge clock) begin
      if (st_ff == ScIdle && scl_req.start) begin
         diff_ff  <= clamped - scl_req.lo;
         size_ff  <= scl_req.size;
         dvs_ff   <= scl_req.hi - scl_req.lo;
         empty_ff <= scl_req.hi <= scl_req.lo;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign scl_rsp.done  = done_ff;
   assign scl_rsp.value = empty_ff ? 16'd0 : sat_coord(quo_ff);

endmodule

`default_nettype wire

### rtl/pointer_touch_event_tracker.sv
// ---------------------------------------------------------------------------
// pointer_touch_event_tracker: merged mouse/touch press and click events
// Top level: command sequencer, pointer state, result buffer and the
// configuration registers.
// ---------------------------------------------------------------------------
// The block takes one command at a time and holds req_stall high until all
// of its results have been transferred. For a touch sample both axes go
// through one shared scale unit (a 32x16 multiply followed by a 16-step
// restoring divider), then the click logic runs and the results follow one
// by one. Mouse, set-position and read-position commands skip the scale
// unit. Every command gives at most two results; rsp_last marks the final
// one. The csr port is always ready and must only be written while no
// command is in flight.
`default_nettype none

module pointer_touch_event_tracker (
   input  wire         clock,
   input  wire         reset,
   // command channel
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_command,
   input  wire         req_moved,
   input  wire         req_left_button,
   input  wire         req_button_down,
   input  wire         req_button_up,
   input  wire         req_button_double,
   input  wire  [15:0] req_pos_x,
   input  wire  [15:0] req_pos_y,
   input  wire  [31:0] req_raw_x,
   input  wire  [31:0] req_raw_y,
   input  wire         req_touch_active,
   // result channel
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [15:0] rsp_x,
   output logic [15:0] rsp_y,
   output logic        rsp_last,
   // configuration write port
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [ptet_pkg::CsrIdxBits-1:0] csr_index,
   input  wire  [31:0] csr_wdata
);
   import ptet_pkg::*;

   localparam logic [2:0] SIdle   = 3'd0;
   localparam logic [2:0] SExec   = 3'd1;
   localparam logic [2:0] SScaleX = 3'd2;
   localparam logic [2:0] SScaleY = 3'd3;
   localparam logic [2:0] STouch  = 3'd4;
   localparam logic [2:0] SSend   = 3'd5;

   // Configuration registers
   logic [15:0] screen_width_ff, screen_height_ff;
   logic [7:0]  ui_scale_ff;
   logic [31:0] touch_min_x_ff, touch_max_x_ff, touch_min_y_ff, touch_max_y_ff;

   // Sequencer and pointer state
   logic [2:0]  state_ff, state_in;
   logic [1:0]  lock_ff, lock_in;
   logic [15:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [15:0] press_x_ff, press_x_in, press_y_ff, press_y_in;
   logic        touch_down_ff, touch_down_in;
   logic        dbl_pend_ff, dbl_pend_in;

   // Latched command
   logic [1:0]  cmd_ff;
   logic        moved_ff, left_ff, down_ff, up_ff, dbl_ff, active_ff;
   logic [15:0] pos_x_ff, pos_y_ff;
   logic [31:0] raw_x_ff, raw_y_ff;

   // Result buffer: first event plus an optional trailing double click
   logic [1:0]  ev_kind_ff, ev_kind_in;
   logic [15:0] ev_x_ff, ev_x_in, ev_y_ff, ev_y_in;
   logic        ev_two_ff, ev_two_in;
   logic        ev_idx_ff, ev_idx_in;

   scl_req_type scl_req;
   scl_rsp_type scl_rsp;

   logic        req_xfer, rsp_xfer;
   logic [12:0] radius;
   logic [15:0] adx, ady;
   logic        far;

   assign req_stall = state_ff != SIdle;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = state_ff == SSend;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   // Shared scale unit, x axis first then y
   always_comb begin
      scl_req.start = 1'b0;
      if (state_ff == SScaleX) begin
         scl_req.raw  = raw_y_ff;
         scl_req.lo   = touch_min_y_ff;
         scl_req.hi   = touch_max_y_ff;
         scl_req.size = screen_height_ff;
      end else begin
         scl_req.raw  = raw_x_ff;
         scl_req.lo   = touch_min_x_ff;
         scl_req.hi   = touch_max_x_ff;
         scl_req.size = screen_width_ff;
      end
      if (state_ff == SExec && cmd_ff == CmdTouch && lock_ff != LockMouse) begin
         scl_req.start = 1'b1;
      end
      if (state_ff == SScaleX && scl_rsp.done) begin
         scl_req.start = 1'b1;
      end
   end

   ptet_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .scl_req (scl_req),
      .scl_rsp (scl_rsp)
   );

   // Double-click distance test against the press point
   assign radius = 13'(ClickRadius) * {5'd0, ui_scale_ff};
   assign adx    = (cur_x_ff > press_x_ff) ? cur_x_ff - press_x_ff : press_x_ff - cur_x_ff;
   assign ady    = (cur_y_ff > press_y_ff) ? cur_y_ff - press_y_ff : press_y_ff - cur_y_ff;
   assign far    = (adx > {3'd0, radius}) || (ady > {3'd0, radius});

   // Command sequencer
   always_comb begin
      state_in      = state_ff;
      lock_in       = lock_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      press_x_in    = press_x_ff;
      press_y_in    = press_y_ff;
      touch_down_in = touch_down_ff;
      dbl_pend_in   = dbl_pend_ff;
      ev_kind_in    = ev_kind_ff;
      ev_x_in       = ev_x_ff;
      ev_y_in       = ev_y_ff;
      ev_two_in     = ev_two_ff;
      ev_idx_in     = ev_idx_ff;
      unique case (state_ff)
         SIdle: begin
            if (req_valid) begin
               state_in = SExec;
            end
         end
         SExec: begin
            ev_x_in   = pos_x_ff;
            ev_y_in   = pos_y_ff;
            ev_two_in = 1'b0;
            ev_idx_in = 1'b0;
            state_in  = SIdle;
            unique case (cmd_ff)
               CmdMouse: begin
                  if (lock_ff != LockTouch) begin
                     if (moved_ff) begin
                        cur_x_in = pos_x_ff;
                        cur_y_in = pos_y_ff;
                     end
                     if (left_ff) begin
                        if (down_ff) begin
                           ev_kind_in = EvPress;
                           lock_in    = LockMouse;
                           state_in   = SSend;
                        end else if (up_ff) begin
                           ev_kind_in = EvRelease;
                           lock_in    = LockNone;
                           state_in   = SSend;
                        end else if (dbl_ff) begin
                           ev_kind_in = EvDouble;
                           state_in   = SSend;
                        end
                     end
                  end
               end
               CmdTouch: begin
                  if (lock_ff != LockMouse) begin
                     state_in = SScaleX;
                  end
               end
               CmdSetPos: begin
                  cur_x_in = pos_x_ff;
                  cur_y_in = pos_y_ff;
               end
               CmdReadPos: begin
                  ev_kind_in = EvPos;
                  ev_x_in    = cur_x_ff;
                  ev_y_in    = cur_y_ff;
                  state_in   = SSend;
               end
               default: begin
                  state_in = SIdle;
               end
            endcase
         end
         SScaleX: begin
            if (scl_rsp.done) begin
               cur_x_in = scl_rsp.value;
               state_in = SScaleY;
            end
         end
         SScaleY: begin
            if (scl_rsp.done) begin
               cur_y_in = scl_rsp.value;
               state_in = STouch;
            end
         end
         STouch: begin
            ev_x_in     = cur_x_ff;
            ev_y_in     = cur_y_ff;
            dbl_pend_in = dbl_pend_ff && !far;
            state_in    = SIdle;
            if (active_ff != touch_down_ff) begin
               touch_down_in = active_ff;
               state_in      = SSend;
               if (active_ff) begin
                  ev_kind_in  = EvPress;
                  lock_in     = LockTouch;
                  press_x_in  = cur_x_ff;
                  press_y_in  = cur_y_ff;
                  dbl_pend_in = 1'b1;
               end else begin
                  ev_kind_in  = EvRelease;
                  lock_in     = LockNone;
                  ev_two_in   = dbl_pend_ff && !far;
                  dbl_pend_in = 1'b0;
               end
            end
         end
         SSend: begin
            if (!rsp_stall) begin
               if (rsp_last) begin
                  ev_idx_in = 1'b0;
                  state_in  = SIdle;
               end else begin
                  ev_idx_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = SIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SIdle;
         lock_ff       <= LockNone;
         cur_x_ff      <= 16'd0;
         cur_y_ff      <= 16'd0;
         press_x_ff    <= 16'd0;
         press_y_ff    <= 16'd0;
         touch_down_ff <= 1'b0;
         dbl_pend_ff   <= 1'b0;
         ev_two_ff     <= 1'b0;
         ev_idx_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lock_ff       <= lock_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         press_x_ff    <= press_x_in;
         press_y_ff    <= press_y_in;
         touch_down_ff <= touch_down_in;
         dbl_pend_ff   <= dbl_pend_in;
         ev_two_ff     <= ev_two_in;
         ev_idx_ff     <= ev_idx_in;
      end
   end

   // Result payload and command capture
   always_ff @(posedge clock) begin
      ev_kind_ff <= ev_kind_in;
      ev_x_ff    <= ev_x_in;
      ev_y_ff    <= ev_y_in;
      if (req_xfer) begin
         cmd_ff    <= req_command;
         moved_ff  <= req_moved;
         left_ff   <= req_left_button;
         down_ff   <= req_button_down;
         up_ff     <= req_button_up;
         dbl_ff    <= req_button_double;
         pos_x_ff  <= req_pos_x;
         pos_y_ff  <= req_pos_y;
         raw_x_ff  <= req_raw_x;
         raw_y_ff  <= req_raw_y;
         active_ff <= req_touch_active;
      end
   end

   // Configuration registers; writes past the last index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= 16'd1024;
         screen_height_ff <= 16'd768;
         ui_scale_ff      <= 8'd1;
         touch_min_x_ff   <= 32'd0;
         touch_max_x_ff   <= 32'd65535;
         touch_min_y_ff   <= 32'd0;
         touch_max_y_ff   <= 32'd65535;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrScreenWidth:  screen_width_ff  <= csr_wdata[15:0];
            CsrScreenHeight: screen_height_ff <= csr_wdata[15:0];
            CsrUiScale:      ui_scale_ff      <= csr_wdata[7:0];
            CsrTouchMinX:    touch_min_x_ff   <= csr_wdata;
            CsrTouchMaxX:    touch_max_x_ff   <= csr_wdata;
            CsrTouchMinY:    touch_min_y_ff   <= csr_wdata;
            CsrTouchMaxY:    touch_max_y_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Result outputs
   assign rsp_event_kind = ev_idx_ff ? EvDouble : ev_kind_ff;
   assign rsp_x          = ev_x_ff;
   assign rsp_y          = ev_y_ff;
   assign rsp_last       = ev_idx_ff || !ev_two_ff;

   // Checks
   a_touch_holds_lock: assert property (@(posedge clock) disable iff (reset)
      touch_down_ff |-> lock_ff == LockTouch)
      else $error("touch held without touch lock");

   a_pending_needs_touch: assert property (@(posedge clock) disable iff (reset)
      dbl_pend_ff |-> touch_down_ff)
      else $error("double click pending with no finger down");

   a_scale_done_expected: assert property (@(posedge clock) disable iff (reset)
      scl_rsp.done |-> (state_ff == SScaleX || state_ff == SScaleY))
      else $error("scale unit finished outside a scale wait");

   a_second_is_double: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_last) |=> (rsp_valid && rsp_last && rsp_event_kind == EvDouble))
      else $error("second result is not a final double click");

   a_no_lock_three: assert property (@(posedge clock) disable iff (reset)
      lock_ff != 2'd3)
      else $error("lock owner took the unused code");

endmodule

`default_nettype wire
